/* rtl/rbad_pkg.sv */
// Shared constants and types for the RGB block average downscaler.
// No dependencies.
package rbad_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_BLOCK_DEF = 64;
  localparam int MAX_HEIGHT    = 4096;
  localparam int SUM_W         = 20;
  localparam int PIX_W         = 8;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd2;
  localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // accept pixel into datapath regs
    logic mem_rd;    // issue accumulator read
    logic acc_wr;    // add and write back
    logic div_start; // begin divisions
    logic div_step;  // one divider step
    logic out_load;  // move quotients to output reg
  } rbad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_full;   // pixel lies inside a full block
    logic last_pix;  // pixel closes a block
    logic div_done;
  } rbad_sts_t;
endpackage

/* rtl/rbad_ctrl.sv */
// Sequencer for the downscaler: pixel accept, read, update, divide, emit.
// Depends on rbad_pkg.
module rbad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rbad_pkg::rbad_sts_t sts,
  output rbad_pkg::rbad_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_DIV, S_OUT} state_t;
  state_t state;

  // accept only in idle; a waiting output word is held off in S_OUT
  assign stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = (state == S_IDLE) && valid;
    cmd.mem_rd    = (state == S_READ);
    cmd.acc_wr    = (state == S_ACC);
    cmd.div_start = (state == S_ACC) && sts.last_pix;
    cmd.div_step  = (state == S_DIV) && !sts.div_done;
    cmd.out_load  = (state == S_OUT) && !(out_valid && out_stall);
  end

  // hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (valid) state <= S_READ;
        S_READ: state <= sts.in_full ? S_ACC : S_IDLE;
        S_ACC:  state <= sts.last_pix ? S_DIV : S_IDLE;
        S_DIV:  if (sts.div_done) state <= S_OUT;
        S_OUT:  if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/rbad_dp.sv */
// Datapath: config regs, position counters, accumulator memory, divider.
// Depends on rbad_pkg.
module rbad_dp #(
  parameter int MAX_WIDTH = rbad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = rbad_pkg::MAX_BLOCK_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index_lo,
  input  logic                cfg_index_ok,
  input  logic [12:0]         cfg_data,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  input  rbad_pkg::rbad_cmd_t cmd,
  output rbad_pkg::rbad_sts_t sts,
  output logic [7:0]          avg_red,
  output logic [7:0]          avg_green,
  output logic [7:0]          avg_blue,
  output logic                row_end,
  output logic                frame_end
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int HW = $clog2(rbad_pkg::MAX_HEIGHT + 1);
  localparam int SW = rbad_pkg::SUM_W;
  localparam int NW = 2 * BW;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [6:0]  block_width, block_height;

  // clamp registers to legal ranges
  logic [CW-1:0] w;
  logic [HW-1:0] h;
  logic [BW-1:0] bw, bh;
  always_comb begin
    w = (image_width == '0) ? CW'(1) :
        ({20'd0, image_width} > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
    h = (image_height == '0) ? HW'(1) :
        ({19'd0, image_height} > 32'(rbad_pkg::MAX_HEIGHT)) ?
        HW'(rbad_pkg::MAX_HEIGHT) : HW'(image_height);
    bw = (block_width == '0) ? BW'(1) :
         ({25'd0, block_width} > 32'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(block_width);
    bh = (block_height == '0) ? BW'(1) :
         ({25'd0, block_height} > 32'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(block_height);
  end

  // position counters; full extents tracked by block ends
  logic [CW-1:0] column_pos;
  logic [HW-1:0] row_pos;
  logic [BW-1:0] col_in_block, row_in_block;
  logic [CW-1:0] blk_idx;       // block column index
  logic [7:0] r_q, g_q, b_q;
  logic first_q, last_q, rend_q, fend_q, full_q;

  logic col_full, row_full, blk_last_col, blk_last_row;
  assign col_full     = ({1'b0, column_pos} + {{(CW - BW + 1){1'b0}}, bw}
                        - {{(CW - BW + 1){1'b0}}, col_in_block}) <= {1'b0, w};
  assign row_full     = ({1'b0, row_pos} + {{(HW - BW + 1){1'b0}}, bh}
                        - {{(HW - BW + 1){1'b0}}, row_in_block}) <= {1'b0, h};
  assign blk_last_col = (col_in_block + 1'b1) == bw;
  assign blk_last_row = (row_in_block + 1'b1) == bh;

  // next block fits on the row?
  logic next_blk_fits, next_row_fits;
  assign next_blk_fits = ({2'b0, column_pos} + 2'd1 + {{(CW - BW + 2){1'b0}}, bw})
                         <= {2'b0, w};
  assign next_row_fits = ({2'b0, row_pos} + 2'd1 + {{(HW - BW + 2){1'b0}}, bh})
                         <= {2'b0, h};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 12'd1; image_height <= 13'd1;
      block_width <= 7'd1;  block_height <= 7'd1;
      column_pos <= '0; row_pos <= '0; col_in_block <= '0; row_in_block <= '0;
      blk_idx <= '0;
    end else if (cfg_we && cfg_index_ok) begin
      case (cfg_index_lo)
        rbad_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        rbad_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        rbad_pkg::REG_BLOCK_WIDTH:  block_width  <= cfg_data[6:0];
        rbad_pkg::REG_BLOCK_HEIGHT: block_height <= cfg_data[6:0];
        default: ;
      endcase
      column_pos <= '0; row_pos <= '0; col_in_block <= '0; row_in_block <= '0;
      blk_idx <= '0;
    end else if (cmd.load) begin
      // advance positions
      if ((column_pos + 1'b1) >= w) begin
        column_pos <= '0; col_in_block <= '0; blk_idx <= '0;
        if ((row_pos + 1'b1) >= h) begin
          row_pos <= '0; row_in_block <= '0;
        end else begin
          row_pos <= row_pos + 1'b1;
          row_in_block <= blk_last_row ? '0 : row_in_block + 1'b1;
        end
      end else begin
        column_pos <= column_pos + 1'b1;
        if (blk_last_col) begin
          col_in_block <= '0;
          blk_idx <= blk_idx + 1'b1;
        end else begin
          col_in_block <= col_in_block + 1'b1;
        end
      end
    end
  end

  // capture the pixel and its position flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_q <= red_in; g_q <= green_in; b_q <= blue_in;
      full_q  <= col_full && row_full;
      first_q <= (col_in_block == '0) && (row_in_block == '0);
      last_q  <= blk_last_col && blk_last_row;
      rend_q  <= blk_last_col && !next_blk_fits;
      fend_q  <= blk_last_col && !next_blk_fits && blk_last_row && !next_row_fits;
    end
  end
  logic [AW-1:0] addr_q;
  always_ff @(posedge clk) begin
    if (cmd.load) addr_q <= blk_idx[AW-1:0];
  end

  // accumulator memory, one entry per block column
  logic [3*SW-1:0] mem [MAX_WIDTH];
  logic [3*SW-1:0] rd_q;
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_q <= mem[addr_q];
  end
  logic [SW-1:0] sr, sg, sb;
  always_comb begin
    if (first_q) begin
      sr = SW'(r_q); sg = SW'(g_q); sb = SW'(b_q);
    end else begin
      sr = rd_q[3*SW-1:2*SW] + SW'(r_q);
      sg = rd_q[2*SW-1:SW] + SW'(g_q);
      sb = rd_q[SW-1:0] + SW'(b_q);
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.acc_wr) mem[addr_q] <= {sr, sg, sb};
  end

  // restoring dividers, one quotient bit per step, three channels share count
  logic [SW-1:0] qr, qg, qb, rr, rg, rb;
  logic [NW-1:0] cnt;
  logic [4:0] steps;
  logic [SW:0] tr, tg, tb;
  assign tr = {rr, qr[SW-1]} - {{(SW + 1 - NW){1'b0}}, cnt};
  assign tg = {rg, qg[SW-1]} - {{(SW + 1 - NW){1'b0}}, cnt};
  assign tb = {rb, qb[SW-1]} - {{(SW + 1 - NW){1'b0}}, cnt};
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.div_start) begin
      qr <= sr; qg <= sg; qb <= sb;
      rr <= '0; rg <= '0; rb <= '0;
      cnt <= NW'(bw) * NW'(bh);
      steps <= 5'(SW);
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
      if (!tr[SW]) begin rr <= tr[SW-1:0]; qr <= {qr[SW-2:0], 1'b1}; end
      else begin rr <= {rr[SW-2:0], qr[SW-1]}; qr <= {qr[SW-2:0], 1'b0}; end
      if (!tg[SW]) begin rg <= tg[SW-1:0]; qg <= {qg[SW-2:0], 1'b1}; end
      else begin rg <= {rg[SW-2:0], qg[SW-1]}; qg <= {qg[SW-2:0], 1'b0}; end
      if (!tb[SW]) begin rb <= tb[SW-1:0]; qb <= {qb[SW-2:0], 1'b1}; end
      else begin rb <= {rb[SW-2:0], qb[SW-1]}; qb <= {qb[SW-2:0], 1'b0}; end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_red <= qr[7:0]; avg_green <= qg[7:0]; avg_blue <= qb[7:0];
      row_end <= rend_q; frame_end <= fend_q;
    end
  end

  assign sts.in_full  = full_q;
  assign sts.last_pix = last_q;
  assign sts.div_done = (steps == '0);
endmodule

/* rtl/rgb_block_average_downscale.sv */
// Top level of the RGB block average downscaler.
// Depends on rbad_pkg, rbad_ctrl, rbad_dp.
//
// Pixels arrive in raster order; each full block_width x block_height block
// yields one word of truncated channel means with row and frame end marks.
// A pixel outside any full block passes through accept and accumulator
// memory read; an inner pixel also through add and write back. A block's
// last pixel then runs the 20-step shared restoring divider, a done check
// and the output state, and waits longer while the previous word still
// waits in the output register. No new pixel is taken until the sequencer
// is back in idle. Any register write restarts the frame.
module rgb_block_average_downscale #(
  parameter int MAX_WIDTH = rbad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = rbad_pkg::MAX_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  avg_red,
  output logic [7:0]  avg_green,
  output logic [7:0]  avg_blue,
  output logic        row_end,
  output logic        frame_end
);
  rbad_pkg::rbad_cmd_t cmd;
  rbad_pkg::rbad_sts_t sts;

  rbad_ctrl u_ctrl (
    .clk, .rst, .valid, .stall, .out_valid, .out_stall, .sts, .cmd
  );

  rbad_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index_lo(cfg_index), .cfg_index_ok(1'b1),
    .cfg_data, .red_in, .green_in, .blue_in, .cmd, .sts,
    .avg_red, .avg_green, .avg_blue, .row_end, .frame_end
  );
endmodule

/* rtl/rbad_check.sv */
// Port-level checks for the downscaler, bound to the top level.
// Depends on rgb_block_average_downscale.
module rbad_check (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] avg_red,
  input logic       row_end,
  input logic       frame_end
);
  // frame end only on a row end
  a_fend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end)) else $error("frame_end without row_end");
  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(avg_red))
    else $error("result changed under stall");
  // after a pixel is taken the block is busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> stall) else $error("pixel taken back to back");
endmodule

bind rgb_block_average_downscale rbad_check u_check (
  .clk, .rst, .valid, .stall, .out_valid, .out_stall, .avg_red, .row_end, .frame_end
);

/* dv/tb.sv */
// Self-checking testbench for rgb_block_average_downscale.
// Depends on rbad_pkg and the RTL of the block; carries its own block-average predictor.
// Runs directed pixels, special register settings, then random frames with idling.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WD_LIMIT   = 5000;
  localparam int DRAIN_WAIT = 40;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       re;
    logic       fe;
  } avg_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        valid;
  logic        stall;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  avg_red;
  logic [7:0]  avg_green;
  logic [7:0]  avg_blue;
  logic        row_end;
  logic        frame_end;

  // predictor state
  logic [11:0] img_w_reg;
  logic [12:0] img_h_reg;
  logic [6:0]  blk_w_reg;
  logic [6:0]  blk_h_reg;
  logic [19:0] acc_r [rbad_pkg::MAX_WIDTH_DEF];
  logic [19:0] acc_g [rbad_pkg::MAX_WIDTH_DEF];
  logic [19:0] acc_b [rbad_pkg::MAX_WIDTH_DEF];
  int unsigned col_pos, row_pos, row_in_blk, col_in_blk;

  avg_word_t avg_q[$];
  int errors;
  int pixels_sent;
  int words_seen;
  int idle_cycles;
  int hold_left;
  bit quiet_out;
  bit quiet_in;

  rgb_block_average_downscale u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .stall(stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .avg_red(avg_red), .avg_green(avg_green), .avg_blue(avg_blue),
    .row_end(row_end), .frame_end(frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    row_in_blk = 0;
    col_in_blk = 0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [12:0] val);
    case (idx)
      rbad_pkg::REG_IMAGE_WIDTH:  img_w_reg = val[11:0];
      rbad_pkg::REG_IMAGE_HEIGHT: img_h_reg = val;
      rbad_pkg::REG_BLOCK_WIDTH:  blk_w_reg = val[6:0];
      rbad_pkg::REG_BLOCK_HEIGHT: blk_h_reg = val[6:0];
      default: ;
    endcase
    restart_frame();
  endfunction

  // Accumulate one pixel; return 1 with the block mean when it closes a block.
  function automatic bit average_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       output avg_word_t w_out);
    int unsigned w, h, bw, bh, full_w, full_h, blk, cnt;
    bit got;
    w = eff_size(img_w_reg, rbad_pkg::MAX_WIDTH_DEF);
    h = eff_size(img_h_reg, rbad_pkg::MAX_HEIGHT);
    bw = eff_size(blk_w_reg, rbad_pkg::MAX_BLOCK_DEF);
    bh = eff_size(blk_h_reg, rbad_pkg::MAX_BLOCK_DEF);
    full_w = (w / bw) * bw;
    full_h = (h / bh) * bh;
    got = 1'b0;
    w_out = '0;
    if (col_pos < full_w && row_pos < full_h) begin
      blk = (col_pos / bw) % rbad_pkg::MAX_WIDTH_DEF;
      if (row_in_blk == 0 && col_in_blk == 0) begin
        acc_r[blk] = 20'(r);
        acc_g[blk] = 20'(g);
        acc_b[blk] = 20'(b);
      end else begin
        acc_r[blk] = acc_r[blk] + 20'(r);
        acc_g[blk] = acc_g[blk] + 20'(g);
        acc_b[blk] = acc_b[blk] + 20'(b);
      end
      if (row_in_blk + 1 == bh && col_in_blk + 1 == bw) begin
        cnt = bw * bh;
        w_out.r = 8'(int'(acc_r[blk]) / cnt);
        w_out.g = 8'(int'(acc_g[blk]) / cnt);
        w_out.b = 8'(int'(acc_b[blk]) / cnt);
        w_out.re = (col_pos + 1 == full_w);
        w_out.fe = w_out.re && (row_pos + 1 == full_h);
        got = 1'b1;
      end
    end
    // advance raster position
    col_in_blk++;
    if (col_in_blk >= bw) col_in_blk = 0;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      col_in_blk = 0;
      row_pos++;
      row_in_blk++;
      if (row_in_blk >= bh) row_in_blk = 0;
      if (row_pos >= h) begin
        row_pos = 0;
        row_in_blk = 0;
      end
    end
    return got;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet_in) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one pixel and hold it until accepted. Use the typed word when given.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit typed, avg_word_t typed_word, bit typed_has);
    int gap;
    avg_word_t w;
    bit got;
    gap = pick_gap();
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    @(posedge clk);
    while (stall) @(posedge clk);
    got = average_pixel(r, g, b, w);
    if (typed) begin
      if (typed_has) avg_q.insert(avg_q.size(), typed_word);
    end else if (got) begin
      avg_q.insert(avg_q.size(), w);
    end
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word has arrived and the block settles.
  task automatic drain();
    valid <= 1'b0;
    while (avg_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [12:0] bw, logic [12:0] bh);
    write_reg(rbad_pkg::REG_IMAGE_WIDTH, w);
    write_reg(rbad_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(rbad_pkg::REG_BLOCK_WIDTH, bw);
    write_reg(rbad_pkg::REG_BLOCK_HEIGHT, bh);
  endtask

  // mode 0: random, mode 1: all full scale
  task automatic send_frame_pixels(int n, int mode);
    logic [7:0] r, g, b;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 15);
      if (mode == 1) begin
        r = 8'hFF; g = 8'hFF; b = 8'hFF;
      end else if (p == 0) begin
        r = 8'h00; g = 8'hFF; b = 8'h00;
      end else if (p == 1) begin
        r = 8'hFF; g = 8'h00; b = 8'hFF;
      end else begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end
      send_pixel(r, g, b, 1'b0, '0, 1'b0);
    end
    drain();
  endtask

  // Check each accepted word against the oldest expectation.
  always @(posedge clk) begin
    avg_word_t e;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (avg_q.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", avg_red, avg_green, avg_blue);
        errors++;
      end else begin
        e = avg_q.pop_front();
        if (avg_red !== e.r) begin
          $error("avg_red expected %0d actual %0d", e.r, avg_red);
          errors++;
        end
        if (avg_green !== e.g) begin
          $error("avg_green expected %0d actual %0d", e.g, avg_green);
          errors++;
        end
        if (avg_blue !== e.b) begin
          $error("avg_blue expected %0d actual %0d", e.b, avg_blue);
          errors++;
        end
        if (row_end !== e.re) begin
          $error("row_end expected %0d actual %0d", e.re, row_end);
          errors++;
        end
        if (frame_end !== e.fe) begin
          $error("frame_end expected %0d actual %0d", e.fe, frame_end);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, occasional bursts, and long hold-offs on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(8, 40);
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: count cycles with no traffic at all.
  always @(posedge clk) begin
    if (rst || (valid && !stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("rgb_block_average_downscale: mismatch");
        $finish;
      end
    end
  end

  // Directed pixels at the reset setting: every pixel is its own block.
  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } px_row_t;

  px_row_t reset_rows [12] = '{
    '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}, '{8'hAA, 8'h55, 8'hAA},
    '{8'h55, 8'hAA, 8'h55}, '{8'h01, 8'h02, 8'h04}, '{8'h80, 8'h40, 8'h20},
    '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
    '{8'h7F, 8'hFE, 8'h01}, '{8'h10, 8'h08, 8'hF0}, '{8'hFF, 8'hFF, 8'h00}
  };

  initial begin
    avg_word_t tw;
    int frames;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    valid = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    out_stall = 1'b0;
    errors = 0;
    pixels_sent = 0;
    words_seen = 0;
    idle_cycles = 0;
    hold_left = 0;
    quiet_out = 1'b0;
    quiet_in = 1'b0;
    img_w_reg = 12'd1;
    img_h_reg = 13'd1;
    blk_w_reg = 7'd1;
    blk_h_reg = 7'd1;
    for (int i = 0; i < rbad_pkg::MAX_WIDTH_DEF; i++) begin
      acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0;
    end
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: each pixel comes back unchanged, both marks set
    foreach (reset_rows[i]) begin
      tw.r = reset_rows[i].r;
      tw.g = reset_rows[i].g;
      tw.b = reset_rows[i].b;
      tw.re = 1'b1;
      tw.fe = 1'b1;
      send_pixel(tw.r, tw.g, tw.b, 1'b1, tw, 1'b1);
    end
    drain();

    // full blocks with a long receiver hold-off so the block backs up
    set_frame(13'd4, 13'd2, 13'd2, 13'd2);
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    send_frame_pixels(24, 0);

    // partial blocks at right and bottom edges
    set_frame(13'd5, 13'd3, 13'd2, 13'd2);
    send_frame_pixels(45, 0);

    // block wider than the image: no words
    set_frame(13'd10, 13'd4, 13'd64, 13'd1);
    send_frame_pixels(20, 0);

    // zero registers act as one
    set_frame(13'd0, 13'd0, 13'd0, 13'd0);
    send_frame_pixels(10, 0);

    // registers above range clamp to the maximum sizes
    set_frame(13'h1FFF, 13'd1, 13'h1FFF, 13'd1);
    send_frame_pixels(128, 0);

    // widest block, full-scale pixels: large sum and divisor
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    set_frame(13'd64, 13'd3, 13'd64, 13'd3);
    send_frame_pixels(192, 1);
    quiet_in = 1'b0;
    quiet_out = 1'b0;

    // random frames, mostly small blocks
    frames = 0;
    while (frames < 2) begin
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      set_frame(13'($urandom_range(1, 12)), 13'($urandom_range(1, 8)),
                13'($urandom_range(1, 4)), 13'($urandom_range(1, 4)));
      send_frame_pixels($urandom_range(40, 70), 0);
      frames++;
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;

    drain();
    $display("covered %0d pixels and %0d averaged words over directed, edge and random frames",
             pixels_sent, words_seen);
    if (errors == 0 && avg_q.size() == 0) begin
      $display("rgb_block_average_downscale: match");
    end else begin
      $display("rgb_block_average_downscale: mismatch");
    end
    $finish;
  end
endmodule
